>>> src/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg
// Types and constants shared by the requantizer datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arq_pkg;

	typedef enum logic [1:0] {
		KIND_INT8  = 2'd0,
		KIND_UINT8 = 2'd1,
		KIND_INT16 = 2'd2,
		KIND_UINT16 = 2'd3
	} kind_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_SRC_SCALE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RCP_SCALE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SRC_ZP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DST_ZP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_IN_KIND   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_KIND  = 3'd5;

	localparam int VAL_W   = 16;               // raw input / output pattern
	localparam int SCALE_W = 32;
	localparam int ZP_W    = 17;
	localparam int MAG_W   = 17;               // |x - zp| < 2^17
	localparam int P1_W    = MAG_W + SCALE_W;  // first product
	localparam int SPLIT_W = 25;               // low slice of first product
	localparam int PP_LO_W = SPLIT_W + SCALE_W;
	localparam int PP_HI_W = P1_W - SPLIT_W + SCALE_W;
	localparam int PROD_W  = P1_W + SCALE_W;   // full exact product
	localparam int IP_W    = 20;               // integer part before saturation
	localparam int ACC_W   = 23;               // signed rounding accumulator

	typedef struct packed {
		logic [SCALE_W-1:0]     src_scale;
		logic [SCALE_W-1:0]     rcp_scale;
		logic signed [ZP_W-1:0] src_zp;
		logic signed [ZP_W-1:0] dst_zp;
		kind_t                  in_kind;
		kind_t                  out_kind;
	} cfg_t;

	function automatic logic signed [ACC_W-1:0] kind_min(input kind_t kind);
		logic signed [ACC_W-1:0] v;
		unique case (kind)
			KIND_INT8:  v = -ACC_W'(128);
			KIND_INT16: v = -ACC_W'(32768);
			default:    v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [ACC_W-1:0] kind_max(input kind_t kind);
		logic signed [ACC_W-1:0] v;
		unique case (kind)
			KIND_INT8:   v = ACC_W'(127);
			KIND_UINT8:  v = ACC_W'(255);
			KIND_INT16:  v = ACC_W'(32767);
			KIND_UINT16: v = ACC_W'(65535);
			default:     v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> src/arq_front.sv
// ----------------------------------------------------------------------------
// arq_front
// Stage 1: decodes the raw pattern, removes the input zero point and splits
// the difference into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_front import arq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [VAL_W-1:0] in_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  neg,
	output logic [MAG_W-1:0]      mag
);

	logic                     valid_s1;
	logic                     neg_s1;
	logic [MAG_W-1:0]         mag_s1;
	logic signed [ZP_W-1:0]   x;
	logic signed [MAG_W:0]    d;
	logic [MAG_W:0]           d_abs;

	always_comb begin
		unique case (cfg.in_kind)
			KIND_INT8:   x = ZP_W'(signed'(in_value[7:0]));
			KIND_UINT8:  x = ZP_W'(in_value[7:0]);
			KIND_INT16:  x = ZP_W'(signed'(in_value));
			KIND_UINT16: x = ZP_W'(in_value);
			default:     x = '0;
		endcase
		d     = (MAG_W+1)'(x) - (MAG_W+1)'(cfg.src_zp);
		d_abs = d[MAG_W] ? (MAG_W+1)'(-d) : (MAG_W+1)'(d);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_s1 <= d[MAG_W];
			mag_s1 <= d_abs[MAG_W-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign neg       = neg_s1;
	assign mag       = mag_s1;

endmodule

`default_nettype wire

>>> src/arq_mult.sv
// ----------------------------------------------------------------------------
// arq_mult
// Stages 2 to 4: exact product magnitude * input scale * reciprocal output scale.
// The second multiply is split into two partial products summed a stage later.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_mult import arq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_neg,
	input  wire logic [MAG_W-1:0] in_mag,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  neg,
	output logic [PROD_W-1:0]     prod
);

	logic                 valid_s2, valid_s3, valid_s4;
	logic                 rdy_s2, rdy_s3, rdy_s4;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [P1_W-1:0]      p1_s2;
	logic [PP_LO_W-1:0]   pp_lo_s3;
	logic [PP_HI_W-1:0]   pp_hi_s3;
	logic [PROD_W-1:0]    prod_s4;

	assign rdy_s4   = !valid_s4 || out_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= in_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			neg_s2 <= in_neg;
			p1_s2  <= P1_W'(in_mag) * P1_W'(cfg.src_scale);
		end
		if (rdy_s3 && valid_s2) begin
			neg_s3   <= neg_s2;
			pp_lo_s3 <= PP_LO_W'(p1_s2[SPLIT_W-1:0]) * PP_LO_W'(cfg.rcp_scale);
			pp_hi_s3 <= PP_HI_W'(p1_s2[P1_W-1:SPLIT_W]) * PP_HI_W'(cfg.rcp_scale);
		end
		if (rdy_s4 && valid_s3) begin
			neg_s4  <= neg_s3;
			prod_s4 <= {pp_hi_s3, {SPLIT_W{1'b0}}} + PROD_W'(pp_lo_s3);
		end
	end

	assign out_valid = valid_s4;
	assign neg       = neg_s4;
	assign prod      = prod_s4;

endmodule

`default_nettype wire

>>> src/arq_round.sv
// ----------------------------------------------------------------------------
// arq_round
// Stages 5 and 6: adds the output zero point, rounds half away from zero,
// saturates to the output type and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_round import arq_pkg::*; #(
	parameter int SCALE_FRAC_BITS = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_neg,
	input  wire logic [PROD_W-1:0] in_prod,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [VAL_W-1:0]       out_value
);

	localparam int PS = 2 * SCALE_FRAC_BITS;

	logic                    valid_s5, valid_s6;
	logic                    rdy_s5, rdy_s6;
	logic                    neg_s5, sat_s5, inc_s5;
	logic signed [ACC_W-1:0] acc_s5;
	logic [VAL_W-1:0]        value_s6;

	logic                    sat, f_zero, f_top, f_rest;
	logic [IP_W-1:0]         ip;
	logic signed [ACC_W-1:0] z_ext, ip_ext, acc;
	logic                    inc_ge, inc_gt;
	logic signed [ACC_W-1:0] r, lim_lo, lim_hi, r_clip;

	// value = acc + fr/one, 0 <= fr < one; inc_ge is fr >= half, inc_gt is fr > half
	always_comb begin
		sat    = |in_prod[PROD_W-1:PS+IP_W];
		ip     = in_prod[PS+IP_W-1:PS];
		f_top  = in_prod[PS-1];
		f_rest = |in_prod[PS-2:0];
		f_zero = !f_top && !f_rest;
		z_ext  = ACC_W'(cfg.dst_zp);
		ip_ext = ACC_W'(ip);
		if (!in_neg) begin
			acc    = z_ext + ip_ext;
			inc_ge = f_top;
			inc_gt = f_top && f_rest;
		end else if (f_zero) begin
			acc    = z_ext - ip_ext;
			inc_ge = 1'b0;
			inc_gt = 1'b0;
		end else begin
			acc    = z_ext - ip_ext - ACC_W'(1);
			inc_ge = !f_top || !f_rest;
			inc_gt = !f_top;
		end
	end

	always_comb begin
		r      = acc_s5 + ACC_W'(inc_s5);
		lim_lo = kind_min(cfg.out_kind);
		lim_hi = kind_max(cfg.out_kind);
		priority if (sat_s5) begin
			r_clip = neg_s5 ? lim_lo : lim_hi;
		end else if (r < lim_lo) begin
			r_clip = lim_lo;
		end else if (r > lim_hi) begin
			r_clip = lim_hi;
		end else begin
			r_clip = r;
		end
	end

	assign rdy_s6   = !valid_s6 || out_ready;
	assign rdy_s5   = !valid_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s5) valid_s5 <= in_valid;
			if (rdy_s6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			neg_s5 <= in_neg;
			sat_s5 <= sat;
			acc_s5 <= acc;
			inc_s5 <= acc[ACC_W-1] ? inc_gt : inc_ge;
		end
		if (rdy_s6 && valid_s5) begin
			if (cfg.out_kind == KIND_INT8 || cfg.out_kind == KIND_UINT8) begin
				value_s6 <= {8'd0, r_clip[7:0]};
			end else begin
				value_s6 <= r_clip[VAL_W-1:0];
			end
		end
	end

	assign out_valid = valid_s6;
	assign out_value = value_s6;

endmodule

`default_nettype wire

>>> src/affine_requantizer.sv
// ----------------------------------------------------------------------------
// affine_requantizer
// Requantizes int8/uint8/int16/uint16 values with fixed-point scales.
// ----------------------------------------------------------------------------
// Each input beat is decoded per in_kind, reduced by the input zero point,
// multiplied by the input scale and the reciprocal output scale (unsigned,
// SCALE_FRAC_BITS fraction bits, kept exact), offset by the output zero point,
// rounded half away from zero and saturated to out_kind. One beat is accepted
// per cycle unless output back-pressure has filled every stage. There are six
// register stages: decode, the two multiply stages, the partial product sum
// and the two rounding stages. Back-pressure on the output fills empty stages
// before the input stalls. Configuration writes take effect at once and are
// meant for when the pipeline is empty.
`default_nettype none

module affine_requantizer import arq_pkg::*; #(
	parameter int SCALE_FRAC_BITS = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [15:0]            s_tdata,   // [15:0] in_value
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [15:0]                 m_tdata    // [15:0] out_value
);

	cfg_t                cfg_q;
	logic                f_valid, f_ready, f_neg;
	logic [MAG_W-1:0]    f_mag;
	logic                p_valid, p_ready, p_neg;
	logic [PROD_W-1:0]   p_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_scale <= SCALE_W'(1) << SCALE_FRAC_BITS;
			cfg_q.rcp_scale <= SCALE_W'(1) << SCALE_FRAC_BITS;
			cfg_q.src_zp    <= '0;
			cfg_q.dst_zp    <= '0;
			cfg_q.in_kind   <= KIND_INT8;
			cfg_q.out_kind  <= KIND_INT8;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SRC_SCALE: cfg_q.src_scale <= cfg_wdata;
				REG_RCP_SCALE: cfg_q.rcp_scale <= cfg_wdata;
				REG_SRC_ZP:    cfg_q.src_zp    <= cfg_wdata[ZP_W-1:0];
				REG_DST_ZP:    cfg_q.dst_zp    <= cfg_wdata[ZP_W-1:0];
				REG_IN_KIND:   cfg_q.in_kind   <= kind_t'(cfg_wdata[1:0]);
				REG_OUT_KIND:  cfg_q.out_kind  <= kind_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	arq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.neg       (f_neg),
		.mag       (f_mag)
	);

	arq_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_neg    (f_neg),
		.in_mag    (f_mag),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.neg       (p_neg),
		.prod      (p_prod)
	);

	arq_round #(
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_neg    (p_neg),
		.in_prod   (p_prod),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata)
	);

endmodule

`default_nettype wire

>>> bench/affine_requantizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_requantizer_test
// Self-checking bench for the affine requantizer.
// ----------------------------------------------------------------------------
// Drives raw input beats through the stream port and predicts each output from
// a shadow copy of the registers. The prediction keeps the exact scale product
// in a wide accumulator, then rounds and saturates. A directed run covers the
// reset settings, ties at one half, zero scales and huge products. Random runs
// then go through a dozen register settings under varying back-pressure.
// Register writes happen only while the pipeline is empty.
// ----------------------------------------------------------------------------

module affine_requantizer_test import arq_pkg::*; ();

	localparam int FRAC_BITS = 20;
	localparam int PROD_SHIFT = 2 * FRAC_BITS;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_SETTING = 115;
	localparam int NUM_SETTINGS = 12;

	// index values the block does not decode; writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(6);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(7);

	class requant_scoreboard;
		cfg_t regs;
		logic [VAL_W-1:0] expected_values[$];
		int errors;

		function new();
			regs.src_scale = 32'd1 << FRAC_BITS;
			regs.rcp_scale = 32'd1 << FRAC_BITS;
			regs.src_zp = '0;
			regs.dst_zp = '0;
			regs.in_kind = KIND_INT8;
			regs.out_kind = KIND_INT8;
			errors = 0;
		endfunction

		function void update_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SRC_SCALE: regs.src_scale = data;
				REG_RCP_SCALE: regs.rcp_scale = data;
				REG_SRC_ZP:    regs.src_zp = data[ZP_W-1:0];
				REG_DST_ZP:    regs.dst_zp = data[ZP_W-1:0];
				REG_IN_KIND:   regs.in_kind = kind_t'(data[1:0]);
				REG_OUT_KIND:  regs.out_kind = kind_t'(data[1:0]);
				default: ;
			endcase
		endfunction

		function logic [VAL_W-1:0] requantize(logic [VAL_W-1:0] raw);
			int x, d, lo_lim, hi_lim;
			logic [127:0] mag, prod;
			logic signed [127:0] zp_wide, acc, half, rnd;
			logic [31:0] res;
			case (regs.in_kind)
				KIND_INT8:  x = $signed(raw[7:0]);
				KIND_UINT8: x = raw[7:0];
				KIND_INT16: x = $signed(raw);
				default:    x = raw;
			endcase
			d = x - regs.src_zp;
			mag = (d < 0) ? -d : d;
			// exact product, up to 81 bits with 40 fraction bits
			prod = mag * 128'(regs.src_scale) * 128'(regs.rcp_scale);
			zp_wide = regs.dst_zp;
			acc = (zp_wide <<< PROD_SHIFT) + ((d < 0) ? -$signed(prod) : $signed(prod));
			half = 128'sd1 <<< (PROD_SHIFT - 1);
			// half away from zero
			if (acc >= 0)
				rnd = (acc + half) >>> PROD_SHIFT;
			else
				rnd = -((half - acc) >>> PROD_SHIFT);
			case (regs.out_kind)
				KIND_INT8:  begin lo_lim = -128;   hi_lim = 127;   end
				KIND_UINT8: begin lo_lim = 0;      hi_lim = 255;   end
				KIND_INT16: begin lo_lim = -32768; hi_lim = 32767; end
				default:    begin lo_lim = 0;      hi_lim = 65535; end
			endcase
			if (rnd < lo_lim)
				res = lo_lim;
			else if (rnd > hi_lim)
				res = hi_lim;
			else
				res = rnd[31:0];
			if (regs.out_kind == KIND_INT8 || regs.out_kind == KIND_UINT8)
				return {8'h00, res[7:0]};
			return res[15:0];
		endfunction

		function void note_input_beat(logic [VAL_W-1:0] raw);
			expected_values.push_back(requantize(raw));
		endfunction

		function void check_output_beat(logic [VAL_W-1:0] got);
			logic [VAL_W-1:0] want;
			if (expected_values.size() == 0) begin
				$error("out_value: expected nothing, actual %h", got);
				errors++;
				return;
			end
			want = expected_values.pop_front();
			if (got !== want) begin
				$error("out_value: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;	// [15:0] in_value
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;	// [15:0] out_value

	int src_idle = 31;
	int sink_idle = 67;
	int stall_cycles = 0;
	requant_scoreboard sb = new();

	affine_requantizer #(.SCALE_FRAC_BITS(FRAC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle);
	end

	// values seen here are the ones from just before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				sb.update_register(cfg_index, cfg_wdata);
			if (s_tvalid && s_tready)
				sb.note_input_beat(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_output_beat(m_tdata);
			if (cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("** affine_requantizer: FAILED **");
		$finish;
	end

	task automatic send_value(input logic [15:0] value);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// upper bits of the narrow registers get noise; the block must ignore them
	task automatic apply_setting(input cfg_t c);
		write_register(REG_SRC_SCALE, c.src_scale);
		write_register(REG_RCP_SCALE, c.rcp_scale);
		write_register(REG_SRC_ZP, {15'($urandom), c.src_zp});
		write_register(REG_DST_ZP, {15'($urandom), c.dst_zp});
		write_register(REG_IN_KIND, {30'($urandom), c.in_kind});
		write_register(REG_OUT_KIND, {30'($urandom), c.out_kind});
		write_register(REG_SPARE_LO, $urandom);
		write_register(REG_SPARE_HI, $urandom);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'd1 << FRAC_BITS;
			2: return 32'd1 << (FRAC_BITS - 1);	// ties at one half
			3: return $urandom_range(0, 4 << FRAC_BITS);
			default: return $urandom_range(1 << (FRAC_BITS - 2), 2 << FRAC_BITS);
		endcase
	endfunction

	function automatic logic signed [ZP_W-1:0] pick_zero_point();
		case ($urandom_range(0, 2))
			0: return ZP_W'($urandom);
			1: return ZP_W'(int'($urandom_range(0, 512)) - 256);
			default: return '0;
		endcase
	endfunction

	function automatic cfg_t random_setting(int k);
		cfg_t c;
		c.src_scale = pick_scale();
		c.rcp_scale = pick_scale();
		c.src_zp = pick_zero_point();
		c.dst_zp = pick_zero_point();
		c.in_kind = kind_t'($urandom_range(0, 3));
		c.out_kind = kind_t'($urandom_range(0, 3));
		if (k == 0)
			c = '{32'd0, 32'd0, 17'sd0, 17'sd0, KIND_INT8, KIND_INT8};
		else if (k == 1)
			c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, -17'sd1, -17'sd1, KIND_UINT16, KIND_UINT16};
		else if (k == 2)
			c = '{32'd1 << FRAC_BITS, 32'd1 << FRAC_BITS, -17'sd65536, 17'sd65535,
				c.in_kind, c.out_kind};
		return c;
	endfunction

	function automatic logic [15:0] pick_value(cfg_t c);
		logic [15:0] corner[8] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'h007F, 16'h0080, 16'h00FF, 16'hFF00};
		case ($urandom_range(0, 7))
			0: return corner[$urandom_range(0, 7)];
			1, 2: return 16'(int'(c.src_zp) + int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		cfg_t plan;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: int8 in, int8 out, unity scales; high byte ignored
		send_value(16'h0000);
		send_value(16'h007F);
		send_value(16'h0080);
		send_value(16'h00FF);
		send_value(16'hFF80);

		// scale of one half: ties go away from zero
		drain();
		apply_setting('{32'd1 << (FRAC_BITS - 1), 32'd1 << FRAC_BITS, 17'sd0, 17'sd0,
			KIND_INT8, KIND_INT16});
		send_value(16'h0005);
		send_value(16'h00FB);
		send_value(16'h0003);
		send_value(16'h00FD);
		send_value(16'h0001);
		send_value(16'h00FF);

		// zero scale leaves only the output zero point, still saturated
		drain();
		apply_setting('{32'd0, 32'hFFFF_FFFF, 17'sd0, 17'sd65535, KIND_UINT16, KIND_INT16});
		send_value(16'hFFFF);
		drain();
		apply_setting('{32'hFFFF_FFFF, 32'd0, 17'sd0, -17'sd65536, KIND_INT16, KIND_UINT8});
		send_value(16'h8000);

		// huge products saturate towards the sign of the offset input
		drain();
		apply_setting('{32'hFFFF_FFFF, 32'hFFFF_FFFF, -17'sd65536, 17'sd0,
			KIND_UINT16, KIND_UINT16});
		send_value(16'hFFFF);
		send_value(16'h0000);
		drain();
		apply_setting('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'sd65535, 17'sd0,
			KIND_INT16, KIND_INT16});
		send_value(16'h8000);
		send_value(16'h0000);

		for (int k = 0; k < NUM_SETTINGS; k++) begin
			if (k < NUM_SETTINGS / 3) begin
				src_idle = 31;
				sink_idle = 67;
			end else if (k < 2 * NUM_SETTINGS / 3) begin
				src_idle = 67;
				sink_idle = 31;
			end else begin
				src_idle = 0;
				sink_idle = 0;
			end
			plan = random_setting(k);
			drain();
			apply_setting(plan);
			repeat (ITEMS_PER_SETTING) send_value(pick_value(plan));
		end

		drain();
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** affine_requantizer: PASSED **");
		else
			$display("** affine_requantizer: FAILED **");
		$finish;
	end

endmodule

>>> files.f
src/arq_pkg.sv
src/arq_front.sv
src/arq_mult.sv
src/arq_round.sv
src/affine_requantizer.sv
bench/affine_requantizer_test.sv
